// File: src/bmpg_pkg.sv
// Shared types and constants of the boxcar motion profile generator.
package bmpg_pkg;

    // Item command codes.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SMOOTHING_TIME = 2'd0;
    localparam logic [1:0] CFG_UPDATE_DIVIDER = 2'd1;
    localparam logic [1:0] CFG_SPEED_DIVIDER  = 2'd2;

    // Configuration reset values.
    localparam logic [10:0] SMOOTHING_TIME_RST = 11'd1024;
    localparam logic [15:0] UPDATE_DIVIDER_RST = 16'd100;
    localparam logic [15:0] SPEED_DIVIDER_RST  = 16'd200;

    // Shared divider: dividend width, divisor magnitude width, counter width.
    localparam int DIV_W     = 48;
    localparam int DIVISOR_W = 32;
    localparam int DIV_CNT_W = 6;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_EXEC,
        OP_LAT_INIT,
        OP_CLR_STEP,
        OP_LAT_PREP,
        OP_DIV_PER,
        OP_CAP_PER,
        OP_DIV_REP,
        OP_CAP_REP,
        OP_FEED_SEL,
        OP_FEED_TAKE,
        OP_FEED_CARRY,
        OP_RING_RD,
        OP_RING_UPD,
        OP_DIV_WIN,
        OP_CAP_WIN,
        OP_STOP_UPD,
        OP_POS_ADD,
        OP_DIV_POS,
        OP_CAP_POS,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic clr_last;
        logic tick_item;
        logic upd_due;
        logic latch_due;
        logic any_rep;
        logic seg_last;
    } dp_status_t;

endpackage

// File: src/boxcar_motion_profile_generator.sv
// Top level of the boxcar motion profile generator.
// Each request produces one result. A shared bit-serial divider sets the
// timing: load and start requests and ticks without a profile update take one
// division each, and a tick with an update takes up to three. The first
// update after a start with the axis stopped also clears the ring and splits
// the segments, with two divisions per segment. After reset the ring is
// cleared in one pass during which no request is taken; configuration writes
// are taken at any time. A finished result waits in an output register while
// the next request is accepted.
module boxcar_motion_profile_generator #(
    parameter int RING_DEPTH = 1024,
    parameter int SEGMENTS   = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [1:0]         s_seg_index,
    input  logic signed [31:0] s_seg_steps,
    input  logic signed [31:0] s_seg_speed,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_speed,
    output logic signed [31:0] m_position,
    output logic               m_stopped,
    output logic               m_pending,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata
);
    import bmpg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    bmpg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bmpg_dp #(
        .RING_DEPTH (RING_DEPTH),
        .SEGMENTS   (SEGMENTS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_command   (s_command),
        .in_seg_index (s_seg_index),
        .in_seg_steps (s_seg_steps),
        .in_seg_speed (s_seg_speed),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .status       (status),
        .out_speed    (m_speed),
        .out_position (m_position),
        .out_stopped  (m_stopped),
        .out_pending  (m_pending)
    );

endmodule

// File: src/bmpg_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module bmpg_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [bmpg_pkg::DIV_W-1:0] dividend,
    input  logic signed [bmpg_pkg::DIVISOR_W:0] divisor,
    output logic                              busy,
    output logic                              done,
    output logic signed [bmpg_pkg::DIV_W-1:0] quotient,
    output logic signed [bmpg_pkg::DIVISOR_W-1:0] remainder
);
    import bmpg_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_W-1:0]     nq_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] d_reg;
    logic                 negq_reg;
    logic                 negr_reg;

    logic [DIV_W-1:0]     dvd_mag;
    logic [DIVISOR_W:0]   dvs_mag;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    // Operand magnitudes and one restoring step.
    always_comb begin
        dvd_mag = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
        dvs_mag = divisor[DIVISOR_W] ? (DIVISOR_W+1)'(-divisor) : (DIVISOR_W+1)'(divisor);
        trial   = {rem_reg, nq_reg[DIV_W-1]};
        ge      = trial >= {1'b0, d_reg};
        diff    = trial - {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= DIV_CNT_W'(DIV_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift register for dividend bits and quotient bits, plus partial remainder.
    always_ff @(posedge aclk) begin
        if (start) begin
            nq_reg   <= dvd_mag;
            rem_reg  <= '0;
            d_reg    <= dvs_mag[DIVISOR_W-1:0];
            negq_reg <= dividend[DIV_W-1] ^ divisor[DIVISOR_W];
            negr_reg <= dividend[DIV_W-1];
        end else if (busy_reg) begin
            nq_reg  <= {nq_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = negq_reg ? -signed'(nq_reg) : signed'(nq_reg);
    assign remainder = negr_reg ? -signed'(rem_reg) : signed'(rem_reg);

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider did not go busy after start");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider reports done while busy");

endmodule

// File: src/bmpg_dp.sv
// Datapath: segment table, smoothing ring, accumulators and the shared divider.
module bmpg_dp #(
    parameter int RING_DEPTH = 1024,
    parameter int SEGMENTS   = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           in_command,
    input  logic [1:0]           in_seg_index,
    input  logic signed [31:0]   in_seg_steps,
    input  logic signed [31:0]   in_seg_speed,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [15:0]          cfg_wdata,
    input  bmpg_pkg::dp_cmd_t    cmd,
    output bmpg_pkg::dp_status_t status,
    output logic signed [31:0]   out_speed,
    output logic signed [31:0]   out_position,
    output logic                 out_stopped,
    output logic                 out_pending
);
    import bmpg_pkg::*;

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int WL_W  = $clog2(RING_DEPTH + 1);
    localparam int SEG_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

    // Configuration registers.
    logic [10:0] st_reg;
    logic [15:0] ud_reg;
    logic [15:0] sd_reg;

    // Captured request.
    logic [1:0]         cmd_reg;
    logic [1:0]         idx_reg;
    logic signed [31:0] in_steps_reg;
    logic signed [31:0] in_speed_reg;

    // Motion state.
    logic signed [31:0] steps_reg [SEGMENTS];
    logic signed [31:0] speed_reg [SEGMENTS];
    logic [31:0]        rep_reg   [SEGMENTS];
    logic signed [31:0] carry_reg;
    logic               pending_reg;
    logic               stopped_reg;
    logic [15:0]        tick_reg;
    logic signed [47:0] ws_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic signed [31:0] fs_reg;
    logic signed [31:0] sm_reg;
    logic               zero_reg;
    logic signed [31:0] pa_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] per_reg;
    logic signed [31:0] pos_reg;
    logic [SEG_W-1:0]   seg_reg;
    logic [PTR_W-1:0]   clr_reg;

    // Smoothing ring and its registered read port.
    logic signed [31:0] ring_mem [RING_DEPTH];
    logic signed [31:0] rd_reg;

    // Divider connections.
    logic                     div_start;
    logic signed [DIV_W-1:0]  div_dvd;
    logic signed [DIVISOR_W:0] div_dvs;
    logic                     div_busy;
    logic                     div_done;
    logic signed [DIV_W-1:0]  div_q;
    logic signed [DIVISOR_W-1:0] div_r;

    // Derived values.
    logic [31:0]        st_ext;
    logic [31:0]        win32;
    logic [WL_W-1:0]    win_len;
    logic signed [31:0] win_s;
    logic [15:0]        tick_inc;
    logic               upd_due;
    logic [SEGMENTS-1:0] rep_nz;
    logic [SEG_W-1:0]   first_seg;
    logic signed [31:0] cur_steps;
    logic signed [31:0] cur_speed;
    logic signed [31:0] spd_abs;
    logic signed [31:0] spd_new;
    logic [WL_W-1:0]    ptr_inc;
    logic [PTR_W-1:0]   ptr_next;
    logic signed [31:0] fs1;
    logic signed [31:0] fs2;
    logic signed [31:0] fs3;
    logic signed [31:0] q1;
    logic signed [31:0] q2;
    logic               ring_we;
    logic [PTR_W-1:0]   ring_waddr;
    logic signed [31:0] ring_wdata;
    logic               load_ok;

    // Window length clamped to one through the ring depth.
    always_comb begin
        st_ext  = 32'(st_reg);
        if (st_reg == 11'd0) begin
            win32 = 32'd1;
        end else if (st_ext > 32'(RING_DEPTH)) begin
            win32 = 32'(RING_DEPTH);
        end else begin
            win32 = st_ext;
        end
        win_len = win32[WL_W-1:0];
        win_s   = signed'(32'(win_len));
    end

    // Tick counter compare and segment selection.
    always_comb begin
        tick_inc  = tick_reg + 16'd1;
        upd_due   = tick_inc >= ud_reg;
        first_seg = '0;
        for (int i = SEGMENTS - 1; i >= 0; i--) begin
            rep_nz[i] = rep_reg[i] != 32'd0;
            if (rep_nz[i]) begin
                first_seg = SEG_W'(i);
            end
        end
        cur_steps = steps_reg[seg_reg];
        cur_speed = speed_reg[seg_reg];
        spd_abs   = cur_speed[31] ? -cur_speed : cur_speed;
        spd_new   = (cur_steps < 32'sd1) ? -spd_abs : spd_abs;
        load_ok   = 32'(idx_reg) < SEGMENTS;
    end

    // Ring pointer advance.
    always_comb begin
        ptr_inc  = WL_W'(ptr_reg) + WL_W'(1);
        ptr_next = (ptr_inc >= win_len) ? '0 : ptr_inc[PTR_W-1:0];
    end

    // Remainder carry of the window average.
    always_comb begin
        fs1 = fs_reg + div_r;
        q1  = div_q[31:0];
        if (fs1 >= win_s) begin
            q1  = div_q[31:0] + 32'sd1;
            fs2 = fs1 - win_s;
        end else begin
            fs2 = fs1;
        end
        q2  = q1;
        fs3 = fs2;
        if (fs2 <= -win_s) begin
            q2  = q1 - 32'sd1;
            fs3 = fs2 + win_s;
        end
    end

    // Divider operand selection.
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        unique case (cmd.op)
            OP_DIV_PER: begin
                div_start = 1'b1;
                div_dvd   = DIV_W'(cur_speed);
                div_dvs   = (DIVISOR_W+1)'(sd_reg);
            end
            OP_DIV_REP: begin
                div_start = 1'b1;
                div_dvd   = DIV_W'(cur_steps);
                div_dvs   = (DIVISOR_W+1)'(per_reg);
            end
            OP_DIV_WIN: begin
                div_start = 1'b1;
                div_dvd   = DIV_W'(ws_reg);
                div_dvs   = (DIVISOR_W+1)'(win_len);
            end
            OP_DIV_POS: begin
                div_start = 1'b1;
                div_dvd   = DIV_W'(signed'({pa_reg, 1'b0}));
                div_dvs   = (DIVISOR_W+1)'((ud_reg == 16'd0) ? 16'd1 : ud_reg);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    bmpg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= SMOOTHING_TIME_RST;
            ud_reg <= UPDATE_DIVIDER_RST;
            sd_reg <= SPEED_DIVIDER_RST;
        end else if (cfg_we) begin
            priority case (cfg_addr)
                CFG_SMOOTHING_TIME: st_reg <= cfg_wdata[10:0];
                CFG_UPDATE_DIVIDER: ud_reg <= cfg_wdata;
                CFG_SPEED_DIVIDER:  sd_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Request capture and output payload.
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_CAPTURE) begin
            cmd_reg      <= in_command;
            idx_reg      <= in_seg_index;
            in_steps_reg <= in_seg_steps;
            in_speed_reg <= in_seg_speed;
        end
        if (cmd.op == OP_CAP_POS) begin
            pos_reg <= div_q[32:1];
        end
        if (cmd.op == OP_CAP_PER) begin
            per_reg <= (sd_reg == 16'd0) ? 32'sd0 : div_q[31:0];
        end
        if (cmd.op == OP_LOAD_OUT) begin
            out_speed    <= sm_reg;
            out_position <= pos_reg;
            out_stopped  <= stopped_reg;
            out_pending  <= pending_reg;
        end
    end

    // Motion and smoothing state updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SEGMENTS; i++) begin
                steps_reg[i] <= '0;
                speed_reg[i] <= '0;
                rep_reg[i]   <= '0;
            end
            carry_reg   <= '0;
            pending_reg <= 1'b0;
            stopped_reg <= 1'b1;
            tick_reg    <= '0;
            ws_reg      <= '0;
            ptr_reg     <= '0;
            fs_reg      <= '0;
            sm_reg      <= '0;
            zero_reg    <= 1'b0;
            pa_reg      <= '0;
            seg_reg     <= '0;
            clr_reg     <= '0;
            x_reg       <= '0;
        end else begin
            unique case (cmd.op)
                OP_EXEC: begin
                    priority case (cmd_reg)
                        CMD_TICK:  tick_reg <= upd_due ? 16'd0 : tick_inc;
                        CMD_LOAD: begin
                            if (load_ok) begin
                                steps_reg[SEG_W'(idx_reg)] <= in_steps_reg;
                                speed_reg[SEG_W'(idx_reg)] <= in_speed_reg;
                            end
                        end
                        CMD_START: pending_reg <= 1'b1;
                        default: begin
                        end
                    endcase
                end
                OP_LAT_INIT: begin
                    ws_reg      <= '0;
                    ptr_reg     <= '0;
                    fs_reg      <= '0;
                    sm_reg      <= '0;
                    carry_reg   <= '0;
                    seg_reg     <= '0;
                    pending_reg <= 1'b0;
                end
                OP_CLR_STEP: begin
                    clr_reg <= (clr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : clr_reg + 1'b1;
                end
                OP_LAT_PREP: begin
                    speed_reg[seg_reg] <= spd_new;
                    steps_reg[seg_reg] <= cur_steps + carry_reg;
                end
                OP_CAP_REP: begin
                    if (per_reg == 32'sd0) begin
                        rep_reg[seg_reg] <= '0;
                        carry_reg        <= cur_steps;
                    end else begin
                        rep_reg[seg_reg] <= div_q[31:0];
                        carry_reg        <= div_r;
                    end
                    if (seg_reg != SEG_W'(SEGMENTS - 1)) begin
                        seg_reg <= seg_reg + 1'b1;
                    end
                end
                OP_FEED_SEL: seg_reg <= first_seg;
                OP_FEED_TAKE: begin
                    x_reg            <= (sd_reg == 16'd0) ? 32'sd0 : div_q[31:0];
                    rep_reg[seg_reg] <= rep_reg[seg_reg] - 32'd1;
                end
                OP_FEED_CARRY: begin
                    x_reg     <= carry_reg;
                    carry_reg <= '0;
                end
                OP_RING_UPD: begin
                    ws_reg  <= ws_reg + 48'(x_reg) - 48'(rd_reg);
                    ptr_reg <= ptr_next;
                end
                OP_CAP_WIN: begin
                    fs_reg   <= fs3;
                    sm_reg   <= q2;
                    zero_reg <= (q2 == 32'sd0) && (fs3 == 32'sd0);
                end
                OP_STOP_UPD: begin
                    stopped_reg <= zero_reg && !(|rep_nz) && (carry_reg == 32'sd0);
                end
                OP_POS_ADD: pa_reg <= pa_reg + sm_reg;
                default: begin
                end
            endcase
        end
    end

    // Ring write: clearing sweep or the new sample.
    always_comb begin
        ring_we    = (cmd.op == OP_CLR_STEP) || (cmd.op == OP_RING_UPD);
        ring_waddr = (cmd.op == OP_CLR_STEP) ? clr_reg : ptr_reg;
        ring_wdata = (cmd.op == OP_CLR_STEP) ? 32'sd0 : x_reg;
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        if (cmd.op == OP_RING_RD) begin
            rd_reg <= ring_mem[ptr_reg];
        end
    end

    // Status toward the controller.
    always_comb begin
        status.div_busy  = div_busy;
        status.div_done  = div_done;
        status.clr_last  = clr_reg == PTR_W'(RING_DEPTH - 1);
        status.tick_item = cmd_reg == CMD_TICK;
        status.upd_due   = upd_due;
        status.latch_due = pending_reg && stopped_reg;
        status.any_rep   = |rep_nz;
        status.seg_last  = seg_reg == SEG_W'(SEGMENTS - 1);
    end

endmodule

// File: src/bmpg_ctrl.sv
// Controller: sequences each request through the datapath and owns the handshakes.
module bmpg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  bmpg_pkg::dp_status_t status,
    output bmpg_pkg::dp_cmd_t    cmd
);
    import bmpg_pkg::*;

    typedef enum logic [4:0] {
        S_BOOT_CLR,
        S_IDLE,
        S_EXEC,
        S_UPD,
        S_CLEAR,
        S_LPREP,
        S_LDIV1,
        S_LWAIT1,
        S_LDIV2,
        S_LWAIT2,
        S_FEED,
        S_FDIV,
        S_FWAIT,
        S_RRD,
        S_RUPD,
        S_WDIV,
        S_WWAIT,
        S_STOPU,
        S_POS_ADD,
        S_POS_DIV,
        S_POS_WAIT,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = state_reg == S_IDLE;
    assign m_valid  = m_valid_reg;

    // Next state and datapath operation.
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_BOOT_CLR: begin
                cmd.op = OP_CLR_STEP;
                if (status.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.op = OP_EXEC;
                if (status.tick_item && status.upd_due) begin
                    state_next = S_UPD;
                end else if (status.tick_item) begin
                    state_next = S_POS_ADD;
                end else begin
                    state_next = S_POS_DIV;
                end
            end
            S_UPD: begin
                if (status.latch_due) begin
                    cmd.op     = OP_LAT_INIT;
                    state_next = S_CLEAR;
                end else begin
                    state_next = S_FEED;
                end
            end
            S_CLEAR: begin
                cmd.op = OP_CLR_STEP;
                if (status.clr_last) state_next = S_LPREP;
            end
            S_LPREP: begin
                cmd.op     = OP_LAT_PREP;
                state_next = S_LDIV1;
            end
            S_LDIV1: begin
                cmd.op     = OP_DIV_PER;
                state_next = S_LWAIT1;
            end
            S_LWAIT1: begin
                if (status.div_done) begin
                    cmd.op     = OP_CAP_PER;
                    state_next = S_LDIV2;
                end
            end
            S_LDIV2: begin
                cmd.op     = OP_DIV_REP;
                state_next = S_LWAIT2;
            end
            S_LWAIT2: begin
                if (status.div_done) begin
                    cmd.op     = OP_CAP_REP;
                    state_next = status.seg_last ? S_FEED : S_LPREP;
                end
            end
            S_FEED: begin
                if (status.any_rep) begin
                    cmd.op     = OP_FEED_SEL;
                    state_next = S_FDIV;
                end else begin
                    cmd.op     = OP_FEED_CARRY;
                    state_next = S_RRD;
                end
            end
            S_FDIV: begin
                cmd.op     = OP_DIV_PER;
                state_next = S_FWAIT;
            end
            S_FWAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_FEED_TAKE;
                    state_next = S_RRD;
                end
            end
            S_RRD: begin
                cmd.op     = OP_RING_RD;
                state_next = S_RUPD;
            end
            S_RUPD: begin
                cmd.op     = OP_RING_UPD;
                state_next = S_WDIV;
            end
            S_WDIV: begin
                cmd.op     = OP_DIV_WIN;
                state_next = S_WWAIT;
            end
            S_WWAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_CAP_WIN;
                    state_next = S_STOPU;
                end
            end
            S_STOPU: begin
                cmd.op     = OP_STOP_UPD;
                state_next = S_POS_ADD;
            end
            S_POS_ADD: begin
                cmd.op     = OP_POS_ADD;
                state_next = S_POS_DIV;
            end
            S_POS_DIV: begin
                cmd.op     = OP_DIV_POS;
                state_next = S_POS_WAIT;
            end
            S_POS_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_CAP_POS;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.op     = OP_LOAD_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_BOOT_CLR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    a_wait_has_div: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_FWAIT || state_reg == S_WWAIT || state_reg == S_POS_WAIT ||
          state_reg == S_LWAIT1 || state_reg == S_LWAIT2) && !status.div_done)
        |-> status.div_busy)
        else $error("waiting on a divider that is not running");

    a_out_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("result not presented after completion");

endmodule
